@@ src/sdrt_pkg.sv @@
package sdrt_pkg;
   localparam int CoordBits = 24;
   localparam int OutBits = CoordBits + 1;
   localparam int DiffBits = CoordBits + 1;
   localparam int ProdBits = 2 * DiffBits + 1;
   localparam int DivBits = 2 * ProdBits;
   localparam int SqBits = 2 * DiffBits + 2;

   typedef struct packed {
      logic                        start_req;
      logic signed [CoordBits-1:0] px;
      logic signed [CoordBits-1:0] py;
      logic signed [CoordBits-1:0] ax;
      logic signed [CoordBits-1:0] ay;
      logic signed [CoordBits-1:0] bx;
      logic signed [CoordBits-1:0] by;
   } req_type;

   typedef struct packed {
      logic [OutBits-1:0] seg_distance;
      logic [OutBits-1:0] min_distance;
      logic [OutBits-1:0] max_distance;
      logic [OutBits-1:0] spread;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic is_sqrt;
   } ctl_type;
endpackage

@@ src/sdrt_divsqrt.sv @@
module sdrt_divsqrt
   import sdrt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             ctl,
   input  logic [DivBits-1:0]  num,
   input  logic [DivBits-1:0]  den,
   output logic                done,
   output logic [DivBits-1:0]  result
);
   localparam int CntBits = $clog2(DivBits + 1);
   logic [DivBits-1:0] x_ff, x_in, q_ff, q_in, d_ff, d_in;
   logic [DivBits+1:0] rem_ff, rem_in, trial;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic mode_ff, mode_in, busy_ff, busy_in;

   always_comb begin
      x_in = x_ff; q_in = q_ff; d_in = d_ff; rem_in = rem_ff;
      cnt_in = cnt_ff; mode_in = mode_ff; busy_in = busy_ff; done = 1'b0;
      trial = '0;
      if (ctl.start) begin
         x_in = num; d_in = den; q_in = '0; rem_in = '0; mode_in = ctl.is_sqrt;
         cnt_in = ctl.is_sqrt ? CntBits'(DivBits / 2) : CntBits'(DivBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mode_ff) begin
            rem_in = {rem_ff[DivBits-1:0], x_ff[DivBits-1 -: 2]};
            x_in = {x_ff[DivBits-3:0], 2'b00};
            trial = {q_ff[DivBits-1:0], 2'b01};
            if (rem_in >= trial) begin
               rem_in = rem_in - trial;
               q_in = {q_ff[DivBits-2:0], 1'b1};
            end else begin
               q_in = {q_ff[DivBits-2:0], 1'b0};
            end
         end else begin
            rem_in = {rem_ff[DivBits:0], x_ff[DivBits-1]};
            x_in = {x_ff[DivBits-2:0], 1'b0};
            trial = {2'b00, d_ff};
            if (rem_in >= trial) begin
               rem_in = rem_in - trial;
               q_in = {q_ff[DivBits-2:0], 1'b1};
            end else begin
               q_in = {q_ff[DivBits-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
         end
      end
      if (busy_ff && !ctl.start && cnt_ff == CntBits'(1)) begin
         done = 1'b1;
      end
   end

   assign result = q_ff;

   always_ff @(posedge clock) begin
      x_ff <= x_in; q_ff <= q_in; d_ff <= d_in; rem_ff <= rem_in;
      cnt_ff <= cnt_in; mode_ff <= mode_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end
endmodule

@@ src/segment_distance_range_tracker.sv @@
// Point to segment distance with running range tracking.
// The req_ channel carries a point and a segment (signed fixed point) and a
// start flag that clears the running minimum and maximum before the item.
// The rsp_ channel returns the floored segment distance, the running minimum
// segment distance, the running maximum endpoint distance and their spread.
// One shared shift-subtract unit performs two square roots of 51 steps for
// the endpoint distances. When the point projects inside a proper segment it
// also performs one division of 102 steps and a third square root of 51 steps.
// The eight dot and square products share one multiplier, and the squared
// cross product is formed on a second one.
// req_ready is high only while no item is in work and no result waits.
// A result stays on rsp_ until its transfer; a stalled receiver simply holds
// the block. Reset clears the running minimum to all ones, the running
// maximum to zero, and empties the block.
module segment_distance_range_tracker
   import sdrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   localparam int CBits = 2 * DiffBits;

   typedef enum logic [11:0] {
      S_IDLE = 12'b000000000001, S_MUL  = 12'b000000000010,
      S_SQA  = 12'b000000000100, S_SQB  = 12'b000000001000,
      S_DEC  = 12'b000000010000, S_DIV  = 12'b000000100000,
      S_SQC  = 12'b000001000000, S_FIN  = 12'b000010000000,
      S_OUT  = 12'b000100000000, S_WA   = 12'b001000000000,
      S_WB   = 12'b010000000000, S_CSQ  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic signed [DiffBits-1:0] v1x_ff, v1y_ff, v2x_ff, v2y_ff, v3x_ff, v3y_ff;
   logic signed [ProdBits-1:0] p_ff [8];
   logic signed [ProdBits-1:0] prod;
   logic signed [DiffBits-1:0] ma, mb;
   logic [3:0] mi_ff, mi_in;
   logic [OutBits-1:0] da_ff, db_ff, seg_ff, min_ff, max_ff, sat;
   logic [OutBits-1:0] far, nmin, nmax;
   logic start_ff;
   logic [DivBits-1:0] num, den, result;
   ctl_type ctl;
   logic done;
   logic signed [ProdBits:0] dot1, dot2, crs;
   logic [ProdBits:0] cmag;
   logic [DivBits-1:0] c2_ff;
   logic [SqBits-1:0] l2;
   logic [CBits-1:0] c_ff, cprod;
   logic [DiffBits-1:0] ca, cb;

   sdrt_divsqrt u_unit (.clock, .reset, .ctl, .num, .den, .done, .result);

   always_comb begin
      case (mi_ff[2:0])
         3'd0: begin ma = v2x_ff; mb = v2x_ff; end
         3'd1: begin ma = v2y_ff; mb = v2y_ff; end
         3'd2: begin ma = v3x_ff; mb = v3x_ff; end
         3'd3: begin ma = v3y_ff; mb = v3y_ff; end
         3'd4: begin ma = v1x_ff; mb = v2x_ff; end
         3'd5: begin ma = v1y_ff; mb = v2y_ff; end
         3'd6: begin ma = v1x_ff; mb = v3x_ff; end
         default: begin ma = v1y_ff; mb = v3y_ff; end
      endcase
      prod = ProdBits'(ma) * ProdBits'(mb);
   end

   assign ca = (mi_ff == 4'd10) ? c_ff[DiffBits-1:0] : c_ff[CBits-1:DiffBits];
   assign cb = (mi_ff == 4'd8) ? c_ff[CBits-1:DiffBits] : c_ff[DiffBits-1:0];
   assign cprod = CBits'(ca) * CBits'(cb);

   assign dot1 = {p_ff[4][ProdBits-1], p_ff[4]} + {p_ff[5][ProdBits-1], p_ff[5]};
   assign dot2 = {p_ff[6][ProdBits-1], p_ff[6]} + {p_ff[7][ProdBits-1], p_ff[7]};
   assign sat = (result > DivBits'({OutBits{1'b1}})) ? {OutBits{1'b1}} : result[OutBits-1:0];

   always_comb begin
      state_in = state_ff; mi_in = mi_ff;
      ctl = '0; num = '0; den = '0;
      case (state_ff)
         S_IDLE: if (req_valid) begin
            state_in = S_MUL; mi_in = '0;
         end
         S_MUL: begin
            mi_in = mi_ff + 1'b1;
            if (mi_ff == 4'd7) begin
               state_in = S_SQA; ctl.start = 1'b1; ctl.is_sqrt = 1'b1;
               num = DivBits'(p_ff[0]) + DivBits'(p_ff[1]);
            end
         end
         S_SQA: if (done) state_in = S_WA;
         S_WA: begin
            state_in = S_SQB; ctl.start = 1'b1; ctl.is_sqrt = 1'b1;
            num = DivBits'(p_ff[2]) + DivBits'(p_ff[3]);
         end
         S_SQB: if (done) state_in = S_WB;
         S_WB: state_in = S_DEC;
         S_DEC: begin
            if ((v1x_ff == '0 && v1y_ff == '0) || dot1 < 0 || dot2 > 0) begin
               state_in = S_FIN;
            end else begin
               state_in = S_CSQ;
            end
         end
         S_CSQ: begin
            mi_in = mi_ff + 1'b1;
            if (mi_ff == 4'd11) begin
               state_in = S_DIV; ctl.start = 1'b1;
               num = c2_ff; den = DivBits'(l2);
            end
         end
         S_DIV: if (done) state_in = S_SQC;
         S_SQC: begin
            if (mi_ff == 4'd8) begin
               ctl.start = 1'b1; ctl.is_sqrt = 1'b1; num = result; mi_in = 4'd9;
            end else if (mi_ff == 4'd10) begin
               state_in = S_FIN;
            end else if (done) begin
               mi_in = 4'd10;
            end
         end
         S_FIN: state_in = S_OUT;
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign crs = {p_ff[0][ProdBits-1], p_ff[0]} - {p_ff[1][ProdBits-1], p_ff[1]};
   assign cmag = crs[ProdBits] ? ProdBits'(0) - crs : crs;
   assign l2 = SqBits'(v1x_ff * v1x_ff) + SqBits'(v1y_ff * v1y_ff);
   assign far = (da_ff > db_ff) ? da_ff : db_ff;
   assign nmin = (start_ff || seg_ff < min_ff) ? seg_ff : min_ff;
   assign nmax = (start_ff || far > max_ff) ? far : max_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         start_ff <= req_data.start_req;
         v1x_ff <= DiffBits'(req_data.bx) - DiffBits'(req_data.ax);
         v1y_ff <= DiffBits'(req_data.by) - DiffBits'(req_data.ay);
         v2x_ff <= DiffBits'(req_data.px) - DiffBits'(req_data.ax);
         v2y_ff <= DiffBits'(req_data.py) - DiffBits'(req_data.ay);
         v3x_ff <= DiffBits'(req_data.px) - DiffBits'(req_data.bx);
         v3y_ff <= DiffBits'(req_data.py) - DiffBits'(req_data.by);
      end
      if (state_ff == S_MUL) p_ff[mi_ff[2:0]] <= prod;
      if (state_ff == S_WA) da_ff <= sat;
      if (state_ff == S_WB) begin
         db_ff <= sat;
         p_ff[0] <= ProdBits'(v1x_ff) * ProdBits'(v2y_ff);
         p_ff[1] <= ProdBits'(v1y_ff) * ProdBits'(v2x_ff);
      end
      if (state_ff == S_DEC) begin
         c_ff <= cmag[CBits-1:0];
         seg_ff <= (dot2 > 0 && !(v1x_ff == '0 && v1y_ff == '0) && !(dot1 < 0))
                   ? db_ff : da_ff;
      end
      if (state_ff == S_CSQ) begin
         if (mi_ff == 4'd8) begin
            c2_ff <= DivBits'(cprod) << CBits;
         end else if (mi_ff == 4'd9) begin
            c2_ff <= c2_ff + (DivBits'(cprod) << (DiffBits + 1));
         end else if (mi_ff == 4'd10) begin
            c2_ff <= c2_ff + DivBits'(cprod);
         end
      end
      if (state_ff == S_SQC && mi_ff == 4'd10) seg_ff <= sat;
      if (reset) begin
         state_ff <= S_IDLE; mi_ff <= '0;
         min_ff <= {OutBits{1'b1}}; max_ff <= '0;
      end else begin
         state_ff <= state_in;
         mi_ff <= (state_ff == S_DIV && done) ? 4'd8 : mi_in;
         if (state_ff == S_FIN) begin
            min_ff <= nmin; max_ff <= nmax;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data.seg_distance = seg_ff;
   assign rsp_data.min_distance = min_ff;
   assign rsp_data.max_distance = max_ff;
   assign rsp_data.spread = (max_ff >= min_ff) ? max_ff - min_ff : '0;
endmodule

@@ src/sdrt_checker.sv @@
module sdrt_checker
   import sdrt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.min_distance <= rsp_data.seg_distance)
      else $error("minimum above segment distance");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after transfer");
endmodule

bind segment_distance_range_tracker sdrt_checker u_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top
   import sdrt_pkg::*;
();

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   localparam logic [OutBits-1:0] OutMax = '1;
   localparam longint CoordMax = (64'sd1 <<< (CoordBits - 1)) - 1;
   localparam longint CoordMin = -(64'sd1 <<< (CoordBits - 1));
   localparam longint CycleLimit = 64'd3000000;

   rsp_type          expected_q[$];
   logic [OutBits-1:0] track_min = '1;
   logic [OutBits-1:0] track_max = '0;
   int               mismatches = 0;
   int               errors = 0;
   longint           cycles = 0;
   bit               hold_rsp = 1'b0;
   bit               stim_done = 1'b0;

   segment_distance_range_tracker uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [OutBits-1:0] clamp_len(longint unsigned v);
      return (v > OutMax) ? OutMax : v[OutBits-1:0];
   endfunction

   function automatic longint unsigned abs64(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic logic [OutBits-1:0] vec_length(longint dx, longint dy);
      longint unsigned ux, uy;
      ux = abs64(dx);
      uy = abs64(dy);
      return clamp_len(int_sqrt(ux * ux + uy * uy));
   endfunction

   function automatic rsp_type predict_distance(req_type r);
      longint v1x, v1y, v2x, v2y, v3x, v3y;
      logic [OutBits-1:0] da, db, seg, far;
      logic [127:0] c2;
      longint unsigned c, l2;
      rsp_type o;
      v1x = longint'(r.bx) - longint'(r.ax);
      v1y = longint'(r.by) - longint'(r.ay);
      v2x = longint'(r.px) - longint'(r.ax);
      v2y = longint'(r.py) - longint'(r.ay);
      v3x = longint'(r.px) - longint'(r.bx);
      v3y = longint'(r.py) - longint'(r.by);
      da = vec_length(v2x, v2y);
      db = vec_length(v3x, v3y);
      if (r.start_req) begin
         track_min = '1;
         track_max = '0;
      end
      if (v1x == 0 && v1y == 0) begin
         seg = da;
      end else if (v1x * v2x + v1y * v2y < 0) begin
         seg = da;
      end else if (v1x * v3x + v1y * v3y > 0) begin
         seg = db;
      end else begin
         c = abs64(v1x * v2y - v1y * v2x);
         l2 = abs64(v1x) * abs64(v1x) + abs64(v1y) * abs64(v1y);
         c2 = 128'(c) * 128'(c);
         c2 = c2 / 128'(l2);
         seg = clamp_len(int_sqrt(c2[63:0]));
      end
      far = (da > db) ? da : db;
      if (seg < track_min) track_min = seg;
      if (far > track_max) track_max = far;
      o.seg_distance = seg;
      o.min_distance = track_min;
      o.max_distance = track_max;
      o.spread = (track_max >= track_min) ? track_max - track_min : '0;
      return o;
   endfunction

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 45) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [CoordBits-1:0] rand_coord();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return CoordBits'(CoordMax);
      if (k == 1) return CoordBits'(CoordMin);
      if (k < 5) return CoordBits'(int'($urandom_range(0, 2047)) - 1024);
      return CoordBits'($urandom);
   endfunction

   task automatic send_item(req_type r);
      int g;
      g = gap_len();
      if (g != 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      expected_q.push_back(predict_distance(r));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_seg(bit st, longint px, longint py, longint ax, longint ay,
                           longint bx, longint by);
      req_type r;
      r.start_req = st;
      r.px = CoordBits'(px); r.py = CoordBits'(py);
      r.ax = CoordBits'(ax); r.ay = CoordBits'(ay);
      r.bx = CoordBits'(bx); r.by = CoordBits'(by);
      send_item(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_seg(1, 0, 0, 0, 0, 0, 0);
      send_seg(0, 256, 256, 512, 512, 512, 512);
      send_seg(0, -512, 0, 0, 0, 1024, 0);
      send_seg(0, 2048, 100, 0, 0, 1024, 0);
      send_seg(0, 500, 300, 0, 0, 1024, 0);
      send_seg(0, 500, -300, 0, 0, 1024, 1024);
      send_seg(1, CoordMax, CoordMax, CoordMin, CoordMin, CoordMin, CoordMin);
      send_seg(0, CoordMin, CoordMax, CoordMax, CoordMin, CoordMax, CoordMin);
      send_seg(1, CoordMax, CoordMin, CoordMin, CoordMax, CoordMax, CoordMax);
      send_seg(0, 0, 0, CoordMin, CoordMin, CoordMax, CoordMax);
      send_seg(0, CoordMax, CoordMin, CoordMin, CoordMax, CoordMax, CoordMin);
      send_seg(1, 0, CoordMax, CoordMin, 0, CoordMax, 0);
      send_seg(0, -1, -1, -1, -1, 1, 1);
      send_seg(1, 10, 10, 0, 0, 0, 0);
      send_seg(0, 0, 0, 0, 0, 0, 0);
      send_seg(0, 256, 0, 0, 0, 256, 0);
      send_seg(0, 0, 0, 0, 0, 256, 0);
   endtask

   task automatic test_random(int n);
      req_type r;
      for (int i = 0; i < n; i++) begin
         r.start_req = ($urandom_range(0, 15) == 0);
         r.px = rand_coord(); r.py = rand_coord();
         r.ax = rand_coord(); r.ay = rand_coord();
         if ($urandom_range(0, 19) == 0) begin
            r.bx = r.ax; r.by = r.ay;
         end else begin
            r.bx = rand_coord(); r.by = rand_coord();
         end
         send_item(r);
      end
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (2000) @(posedge clock);
            hold_rsp = 1'b0;
         end
         test_random(5);
      join
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drained();
      test_backpressure();
      test_random(1620);
      wait_drained();
      repeat (400) @(posedge clock);
      stim_done = 1'b1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (hold_rsp) rsp_ready <= 1'b0;
         else if ($urandom_range(0, 99) < 95) rsp_ready <= ($urandom_range(0, 3) != 0);
         else rsp_ready <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            errors++;
            if (mismatches < 10) $display("unexpected transfer: %p", rsp_data);
            mismatches++;
         end else begin
            e = expected_q.pop_front();
            if (e !== rsp_data) begin
               errors++;
               if (mismatches < 10) begin
                  $display("mismatch: expected seg %0d min %0d max %0d spread %0d",
                           e.seg_distance, e.min_distance, e.max_distance, e.spread);
                  $display("          got seg %0d min %0d max %0d spread %0d",
                           rsp_data.seg_distance, rsp_data.min_distance,
                           rsp_data.max_distance, rsp_data.spread);
               end
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (stim_done) begin
         if (errors == 0 && expected_q.size() == 0)
            $display("segment_distance_range_tracker verification clean");
         else
            $display("segment_distance_range_tracker verification failed");
         $finish;
      end else if (cycles > CycleLimit) begin
         $display("segment_distance_range_tracker verification failed");
         $finish;
      end
   end
endmodule

@@ files.f @@
src/sdrt_pkg.sv
src/sdrt_divsqrt.sv
src/segment_distance_range_tracker.sv
src/sdrt_checker.sv
test/tb_top.sv
